// ===== hw/rtl/buvw_pkg.sv =====
// ----------------------------------------------------------------------------
// buvw_pkg
// Shared types and constants for the baseline u,v,w and rate generator.
// ----------------------------------------------------------------------------
package buvw_pkg;

  localparam int POS_W  = 35;
  localparam int BASE_W = 36;
  localparam int UVW_W  = 36;
  localparam int RATE_W = 33;

  // cycles from the angle at the sincos input to the registered result
  localparam int SC_LAT = 18;

  localparam logic [30:0] Q_ONE     = 31'h4000_0000;
  localparam int          Q_HALF_I  = 2**29;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  // sine and cosine in Q30
  typedef struct packed {
    logic signed [31:0] sin_q;
    logic signed [31:0] cos_q;
  } sc_t;

endpackage

// ===== hw/rtl/buvw_sincos.sv =====
// ----------------------------------------------------------------------------
// buvw_sincos
// Pipelined sine and cosine of a turn fraction: quadrant fold, then Horner
// evaluation of the Taylor series, two register stages per Horner step.
// ----------------------------------------------------------------------------
module buvw_sincos #(
  parameter int ANGLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  ce,
  input  logic [ANGLE_BITS-1:0] angle,
  output buvw_pkg::sc_t         result
);

  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam int SIN_HALF [SIN_STEPS] = '{78, 55, 36, 21, 10, 3};
  localparam int COS_HALF [COS_STEPS] = '{91, 66, 45, 28, 15, 6, 1};
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int XP = 2 * SIN_STEPS + 1;
  localparam int QP = 2 * COS_STEPS + 1;

  logic [31:0] a32, a_rnd, ru, r_abs;
  logic [29:0] r1;
  logic [1:0]  q1, q2;
  logic        neg1, neg2;
  logic [29:0] x_a2;

  logic [29:0] x_pipe   [XP];
  logic [29:0] x2_pipe  [XP];
  logic [1:0]  q_pipe   [QP];
  logic        neg_pipe [QP];

  logic [60:0] sm1 [SIN_STEPS];
  logic [67:0] sm2 [SIN_STEPS];
  logic [60:0] cm1 [COS_STEPS];
  logic [67:0] cm2 [COS_STEPS];

  logic [60:0]        sprod, sprod_d;
  logic [30:0]        s_t, c_t, s_mag;
  logic signed [31:0] s0, c0, sin_sel, cos_sel;

  // fold to the nearest quadrant, residue within an eighth of a turn
  always_comb begin
    a32   = 32'(angle) << (32 - ANGLE_BITS);
    a_rnd = a32 + 32'h2000_0000;
    ru    = a32 - {a_rnd[31:30], 30'd0};
    r_abs = ru[31] ? (32'd0 - ru) : ru;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r1         <= r_abs[29:0];
      q1         <= a_rnd[31:30];
      neg1       <= ru[31];
      x_a2       <= 30'((62'(r1) * 62'(PI_Q30) + 62'(2**30)) >> 31);
      q2         <= q1;
      neg2       <= neg1;
      x_pipe[0]  <= x_a2;
      x2_pipe[0] <= 30'((60'(x_a2) * 60'(x_a2) + 60'(buvw_pkg::Q_HALF_I)) >> 30);
      q_pipe[0]  <= q2;
      neg_pipe[0] <= neg2;
      for (int n = 1; n < XP; n++) begin
        x_pipe[n]  <= x_pipe[n-1];
        x2_pipe[n] <= x2_pipe[n-1];
      end
      for (int n = 1; n < QP; n++) begin
        q_pipe[n]   <= q_pipe[n-1];
        neg_pipe[n] <= neg_pipe[n-1];
      end
    end
  end

  // one Horner step: t' = 1 - round(x2*t) / (2*D), exact reciprocal divide
  for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
    localparam int D = SIN_HALF[k];
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 37) + 64'(D) - 64'd1) / 64'(D);
    localparam logic [37:0] RECIP = RECIP_FULL[37:0];
    logic [30:0] t_in, p;
    logic [29:0] np;
    if (k == 0) begin : g_first
      assign t_in = buvw_pkg::Q_ONE;
    end else begin : g_next
      assign t_in = buvw_pkg::Q_ONE - sm2[k-1][67:37];
    end
    always_comb begin
      p  = 31'((sm1[k] + 61'(buvw_pkg::Q_HALF_I)) >> 30);
      np = 30'((32'(p) + 32'(D)) >> 1);
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        sm1[k] <= 61'(x2_pipe[2*k]) * 61'(t_in);
        sm2[k] <= 68'(np) * 68'(RECIP);
      end
    end
  end

  for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
    localparam int D = COS_HALF[k];
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 37) + 64'(D) - 64'd1) / 64'(D);
    localparam logic [37:0] RECIP = RECIP_FULL[37:0];
    logic [30:0] t_in, p;
    logic [29:0] np;
    if (k == 0) begin : g_first
      assign t_in = buvw_pkg::Q_ONE;
    end else begin : g_next
      assign t_in = buvw_pkg::Q_ONE - cm2[k-1][67:37];
    end
    always_comb begin
      p  = 31'((cm1[k] + 61'(buvw_pkg::Q_HALF_I)) >> 30);
      np = 30'((32'(p) + 32'(D)) >> 1);
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        cm1[k] <= 61'(x2_pipe[2*k]) * 61'(t_in);
        cm2[k] <= 68'(np) * 68'(RECIP);
      end
    end
  end

  always_comb begin
    s_t   = buvw_pkg::Q_ONE - sm2[SIN_STEPS-1][67:37];
    c_t   = buvw_pkg::Q_ONE - cm2[COS_STEPS-1][67:37];
    s_mag = 31'((sprod_d + 61'(buvw_pkg::Q_HALF_I)) >> 30);
    s0    = neg_pipe[QP-1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    c0    = $signed({1'b0, c_t});
    // odd quadrants swap sine and cosine; then negate per quadrant
    sin_sel = q_pipe[QP-1][0] ? c0 : s0;
    cos_sel = q_pipe[QP-1][0] ? s0 : c0;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sprod        <= 61'(x_pipe[XP-1]) * 61'(s_t);
      sprod_d      <= sprod;
      result.sin_q <= q_pipe[QP-1][1] ? -sin_sel : sin_sel;
      result.cos_q <= (q_pipe[QP-1][1] ^ q_pipe[QP-1][0]) ? -cos_sel : cos_sel;
    end
  end

endmodule

// ===== hw/rtl/baseline_uvw_and_rate_generator.sv =====
// ----------------------------------------------------------------------------
// baseline_uvw_and_rate_generator
// Antenna position table and baseline u,v,w / u,v,w rate pipeline.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready/s_tdata with the operation on
// s_tuser. A load word writes one antenna position and gives no result; a
// compute word gives one result word on m_tvalid/m_tready/m_tdata, with the
// bad antenna flag on m_tuser (all data zero when it is set).
// cfg_wr_en/cfg_wr_data write the antenna count; write it only while idle.
// Steps after a compute word is accepted: the table read and angle capture
// happen at the accepting edge, then the two sincos units, the coefficient
// products, the rate scaling, the dot products and rounding, and saturation
// into the output register. Throughput: one word per cycle, sustained, while
// the receiver does not stall.
// The table has two registered read ports and one write port, so a compute
// may directly follow the load of either of its antennas.
// Reset empties the pipeline and sets the antenna count to 2; the table is
// not cleared, and an entry must be loaded before a compute reads it.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module baseline_uvw_and_rate_generator #(
  parameter int MAX_ANTENNAS = 64,
  parameter int ANGLE_BITS   = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic s_tvalid,
  output logic s_tready,
  // first_antenna, second_antenna, pos_x, pos_y, pos_z, hour_angle, declination
  input  logic [((117 + 2*ANGLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // operation
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // u_mm, v_mm, w_mm, u_rate, v_rate, w_rate
  output logic [207:0] m_tdata,
  // bad_antenna
  output logic m_tuser
);

  localparam int AW      = $clog2(MAX_ANTENNAS);
  localparam int IW      = (AW > 6) ? AW : 6;
  localparam int OUT_ST  = buvw_pkg::SC_LAT + 8;
  localparam int B_DLY   = buvw_pkg::SC_LAT + 4;
  localparam int HA_LO   = 117;
  localparam int DEC_LO  = 117 + ANGLE_BITS;
  localparam logic [IW:0]  MAX_IDX = (IW+1)'(MAX_ANTENNAS);
  localparam logic [28:0]  HRATE_UM_Q32 = 29'd313193310;
  localparam logic signed [39:0] UVW_MAX  = 40'sd34359738367;
  localparam logic signed [39:0] UVW_MIN  = -40'sd34359738368;
  localparam logic signed [39:0] RATE_MAX = 40'sd4294967295;
  localparam logic signed [39:0] RATE_MIN = -40'sd4294967296;

  logic [6:0] antenna_count;
  logic       ce, accept, ld_en;
  logic [IW-1:0] i_ext, j_ext;
  logic          bad_in;
  logic [AW-1:0] ai, aj;

  logic [OUT_ST:0] vld, bad;

  buvw_pkg::pos_t mem [MAX_ANTENNAS];
  buvw_pkg::pos_t rd_i, rd_j;
  logic [ANGLE_BITS-1:0] ha0, dec0;

  logic signed [buvw_pkg::BASE_W-1:0] b_pipe [B_DLY][3];
  buvw_pkg::sc_t sc_h, sc_d;

  logic [60:0]        pm19 [4];
  logic               psg19 [4];
  logic signed [31:0] sh19, ch19, sd19, cd19;
  logic signed [31:0] qp [4];
  logic signed [31:0] kc20 [8], kc21 [8], kc22 [8];
  logic signed [31:0] ra20 [6];
  logic [59:0]        rm21 [6];
  logic               rsg21 [6];
  logic signed [31:0] rc22 [6];
  logic signed [31:0] km [6][3];
  logic signed [50:0] pl23 [6][3];
  logic signed [49:0] ph23 [6][3];
  logic signed [69:0] term24 [6][3];
  logic signed [39:0] acc25 [6];
  logic signed [39:0] sat [6];
  logic signed [buvw_pkg::UVW_W-1:0]  u_mm, v_mm, w_mm;
  logic signed [buvw_pkg::RATE_W-1:0] u_rate, v_rate, w_rate;

  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    logic [31:0] a;
    a = v[31] ? (32'd0 - 32'(v)) : 32'(v);
    return a[30:0];
  endfunction

  function automatic logic signed [31:0] signed31(input logic [30:0] m, input logic neg);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // the whole pipeline advances unless a result waits on the receiver
  assign ce       = !vld[OUT_ST] || m_tready;
  assign s_tready = ce && !rst;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    i_ext  = IW'(s_tdata[5:0]);
    j_ext  = IW'(s_tdata[11:6]);
    ai     = i_ext[AW-1:0];
    aj     = j_ext[AW-1:0];
    bad_in = ({1'b0, i_ext} >= (IW+1)'(antenna_count)) ||
             ({1'b0, j_ext} >= (IW+1)'(antenna_count)) ||
             ({1'b0, i_ext} >= MAX_IDX) || ({1'b0, j_ext} >= MAX_IDX);
    ld_en  = accept && (buvw_pkg::op_t'(s_tuser) == buvw_pkg::OP_LOAD) &&
             ({1'b0, i_ext} < MAX_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      antenna_count <= 7'd2;
    end else if (cfg_wr_en) begin
      antenna_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[OUT_ST-1:0],
              accept && (buvw_pkg::op_t'(s_tuser) == buvw_pkg::OP_COMPUTE)};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bad <= {bad[OUT_ST-1:0], bad_in};
    end
  end

  // antenna table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ld_en) begin
      mem[ai] <= '{x: s_tdata[46:12], y: s_tdata[81:47], z: s_tdata[116:82]};
    end
    if (ce) begin
      rd_i <= mem[ai];
      rd_j <= mem[aj];
      ha0  <= s_tdata[HA_LO +: ANGLE_BITS];
      dec0 <= s_tdata[DEC_LO +: ANGLE_BITS];
    end
  end

  // baseline, then hold it until the coefficients are ready
  always_ff @(posedge clk) begin
    if (ce) begin
      b_pipe[0][0] <= 36'(rd_j.x) - 36'(rd_i.x);
      b_pipe[0][1] <= 36'(rd_j.y) - 36'(rd_i.y);
      b_pipe[0][2] <= 36'(rd_j.z) - 36'(rd_i.z);
      for (int n = 1; n < B_DLY; n++) begin
        b_pipe[n] <= b_pipe[n-1];
      end
    end
  end

  buvw_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_ha (
    .clk(clk), .ce(ce), .angle(ha0), .result(sc_h)
  );

  buvw_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_dec (
    .clk(clk), .ce(ce), .angle(dec0), .result(sc_d)
  );

  // rounded Q30 products: ch*sd, sh*sd, sh*cd, ch*cd
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      qp[n] = signed31(31'((pm19[n] + 61'(buvw_pkg::Q_HALF_I)) >> 30), psg19[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pm19[0]  <= 61'(mag31(sc_h.cos_q)) * 61'(mag31(sc_d.sin_q));
      pm19[1]  <= 61'(mag31(sc_h.sin_q)) * 61'(mag31(sc_d.sin_q));
      pm19[2]  <= 61'(mag31(sc_h.sin_q)) * 61'(mag31(sc_d.cos_q));
      pm19[3]  <= 61'(mag31(sc_h.cos_q)) * 61'(mag31(sc_d.cos_q));
      psg19[0] <= sc_h.cos_q[31] ^ sc_d.sin_q[31];
      psg19[1] <= sc_h.sin_q[31] ^ sc_d.sin_q[31];
      psg19[2] <= sc_h.sin_q[31] ^ sc_d.cos_q[31];
      psg19[3] <= sc_h.cos_q[31] ^ sc_d.cos_q[31];
      sh19 <= sc_h.sin_q;
      ch19 <= sc_h.cos_q;
      sd19 <= sc_d.sin_q;
      cd19 <= sc_d.cos_q;

      // u: sh, ch; v: -ch.sd, sh.sd, cd; w: ch.cd, -sh.cd, sd
      kc20[0] <= sh19;
      kc20[1] <= ch19;
      kc20[2] <= -qp[0];
      kc20[3] <= qp[1];
      kc20[4] <= cd19;
      kc20[5] <= qp[3];
      kc20[6] <= -qp[2];
      kc20[7] <= sd19;
      ra20[0] <= ch19;
      ra20[1] <= -sh19;
      ra20[2] <= qp[1];
      ra20[3] <= qp[0];
      ra20[4] <= -qp[2];
      ra20[5] <= -qp[3];

      kc21 <= kc20;
      for (int n = 0; n < 6; n++) begin
        rm21[n]  <= 60'(mag31(ra20[n])) * 60'(HRATE_UM_Q32);
        rsg21[n] <= ra20[n][31];
      end

      kc22 <= kc21;
      for (int n = 0; n < 6; n++) begin
        rc22[n] <= signed31(31'((rm21[n] + 60'(64'd1 << 31)) >> 32), rsg21[n]);
      end
    end
  end

  always_comb begin
    km[0][0] = kc22[0]; km[0][1] = kc22[1]; km[0][2] = '0;
    km[1][0] = kc22[2]; km[1][1] = kc22[3]; km[1][2] = kc22[4];
    km[2][0] = kc22[5]; km[2][1] = kc22[6]; km[2][2] = kc22[7];
    km[3][0] = rc22[0]; km[3][1] = rc22[1]; km[3][2] = '0;
    km[4][0] = rc22[2]; km[4][1] = rc22[3]; km[4][2] = '0;
    km[5][0] = rc22[4]; km[5][1] = rc22[5]; km[5][2] = '0;
  end

  // exact dot products, baseline split into two 18-bit halves
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int o = 0; o < 6; o++) begin
        for (int t = 0; t < 3; t++) begin
          pl23[o][t] <= $signed({1'b0, b_pipe[B_DLY-1][t][17:0]}) * km[o][t];
          ph23[o][t] <= $signed(b_pipe[B_DLY-1][t][35:18]) * km[o][t];
          term24[o][t] <= (70'(ph23[o][t]) <<< 18) + 70'(pl23[o][t]);
        end
        acc25[o] <= 40'((term24[o][0] + term24[o][1] + term24[o][2] +
                         70'sd536870912) >>> 30);
      end
    end
  end

  always_comb begin
    for (int o = 0; o < 3; o++) begin
      sat[o] = (acc25[o] > UVW_MAX) ? UVW_MAX :
               ((acc25[o] < UVW_MIN) ? UVW_MIN : acc25[o]);
    end
    for (int o = 3; o < 6; o++) begin
      sat[o] = (acc25[o] > RATE_MAX) ? RATE_MAX :
               ((acc25[o] < RATE_MIN) ? RATE_MIN : acc25[o]);
    end
  end

  // output register: saturate, drop to zero on a rejected index
  always_ff @(posedge clk) begin
    if (ce) begin
      if (bad[OUT_ST-1]) begin
        u_mm   <= '0;
        v_mm   <= '0;
        w_mm   <= '0;
        u_rate <= '0;
        v_rate <= '0;
        w_rate <= '0;
      end else begin
        u_mm   <= sat[0][buvw_pkg::UVW_W-1:0];
        v_mm   <= sat[1][buvw_pkg::UVW_W-1:0];
        w_mm   <= sat[2][buvw_pkg::UVW_W-1:0];
        u_rate <= sat[3][buvw_pkg::RATE_W-1:0];
        v_rate <= sat[4][buvw_pkg::RATE_W-1:0];
        w_rate <= sat[5][buvw_pkg::RATE_W-1:0];
      end
    end
  end

  assign m_tvalid = vld[OUT_ST];
  assign m_tuser  = bad[OUT_ST];
  assign m_tdata  = {1'b0, w_rate, v_rate, u_rate, w_mm, v_mm, u_mm};

endmodule

// ===== hw/rtl/buvw_checker.sv =====
// ----------------------------------------------------------------------------
// buvw_checker
// Port-level checks on the baseline u,v,w generator, bound to the top level.
// ----------------------------------------------------------------------------
module buvw_port_checks (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [207:0] m_tdata,
  input logic         m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("rejected index with non-zero data");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off with empty output register");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipeline stalled");

endmodule

bind baseline_uvw_and_rate_generator buvw_port_checks u_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser)
);
